// ===== rtl/rcpd_pkg.sv =====
// Shared types and constants for the RC pulse to differential drive mixer.
`timescale 1ns / 1ps
`default_nettype none
package rcpd_pkg;

  localparam int COUNT_BITS = 16;
  localparam int QUO_BITS   = 15;
  localparam int MAG_BITS   = 16;
  localparam int DRIVE_BITS = 12;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [MAG_BITS-1:0] ONE_Q15 = 16'h8000;

  // capture sources
  localparam logic [1:0] OP_STEER    = 2'd0;
  localparam logic [1:0] OP_THROTTLE = 2'd1;
  localparam logic [1:0] OP_RANGE    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAXPOWER = 3'd5;

  // reset values
  localparam logic [15:0] RST_CENTER   = 16'h008C;
  localparam logic [15:0] RST_MIN      = 16'h0060;
  localparam logic [15:0] RST_MAX      = 16'h00B9;
  localparam logic [7:0]  RST_MARGIN   = 8'd2;
  localparam logic [15:0] RST_SAFE     = 16'h0050;
  localparam logic [11:0] RST_MAXPOWER = 12'd1000;

  // multiplier operand selection
  localparam logic [1:0] MUL_INNER = 2'd0;
  localparam logic [1:0] MUL_LEFT  = 2'd1;
  localparam logic [1:0] MUL_RIGHT = 2'd2;

  typedef struct packed {
    logic [1:0]            op;
    logic [COUNT_BITS-1:0] captured_count;
  } in_t;

  typedef struct packed {
    logic [DRIVE_BITS-1:0] left_drive;
    logic [DRIVE_BITS-1:0] right_drive;
    logic                  forward;
  } out_t;

  typedef struct packed {
    logic [15:0]           stick_center;
    logic [15:0]           stick_min;
    logic [15:0]           stick_max;
    logic [7:0]            dead_margin;
    logic [15:0]           safe_distance;
    logic [DRIVE_BITS-1:0] full_drive;
  } cfg_t;

  typedef struct packed {
    logic       capture;
    logic       norm_start;
    logic       norm_sel;     // 0 steering, 1 throttle
    logic       mul_go;
    logic [1:0] mul_sel;
    logic       inner_load;
    logic       left_load;
    logic       result_load;
  } cmd_t;

  typedef struct packed {
    logic norm_done;
    logic out_full;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/rc_pulse_to_differential_drive_top.sv =====
// Top level of the RC pulse to differential drive mixer.
//
//   channel   signals                        payload
//   input     in_valid / in_ready            in_data  (op, captured_count)
//   output    out_valid / out_ready          out_data (left_drive, right_drive, forward)
//   config    cfg_we, cfg_index              cfg_data (16 bit, low bits used)
//
// A transaction runs from acceptance to result through the two 15-step normalizing
// divisions on the shared divider and three passes through the shared multiplier.
// A new input is taken once the previous one has left the sequencer, even while its
// result waits in the output register.
// Synchronous reset restores the register defaults and clears all channel state.
// A stalled output holds the sequencer at its final step until out_ready.
`timescale 1ns / 1ps
`default_nettype none
module rc_pulse_to_differential_drive_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire rcpd_pkg::in_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output rcpd_pkg::out_t                      out_data,
  input  wire logic                           cfg_we,
  input  wire logic [rcpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rcpd_pkg::CFG_W-1:0]     cfg_data
);

  rcpd_pkg::cfg_t  cfg;
  rcpd_pkg::cmd_t  cmd;
  rcpd_pkg::stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stick_center  <= rcpd_pkg::RST_CENTER;
      cfg.stick_min     <= rcpd_pkg::RST_MIN;
      cfg.stick_max     <= rcpd_pkg::RST_MAX;
      cfg.dead_margin   <= rcpd_pkg::RST_MARGIN;
      cfg.safe_distance <= rcpd_pkg::RST_SAFE;
      cfg.full_drive    <= rcpd_pkg::RST_MAXPOWER;
    end else if (cfg_we) begin
      case (cfg_index)
        rcpd_pkg::REG_CENTER:   cfg.stick_center  <= cfg_data;
        rcpd_pkg::REG_MIN:      cfg.stick_min     <= cfg_data;
        rcpd_pkg::REG_MAX:      cfg.stick_max     <= cfg_data;
        rcpd_pkg::REG_MARGIN:   cfg.dead_margin   <= cfg_data[7:0];
        rcpd_pkg::REG_SAFE:     cfg.safe_distance <= cfg_data;
        rcpd_pkg::REG_MAXPOWER: cfg.full_drive    <= cfg_data[rcpd_pkg::DRIVE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  rcpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  rcpd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/rcpd_div.sv =====
// Restoring divider, one quotient bit per cycle, for fractions below one.
`timescale 1ns / 1ps
`default_nettype none
module rcpd_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [15:0]                   num,
  input  wire logic [15:0]                   den,
  output logic      [rcpd_pkg::QUO_BITS-1:0] quo,
  output logic                               done
);

  logic [15:0] rem;
  logic [15:0] dsr;
  logic [3:0]  cnt;
  logic        busy;
  logic [16:0] shifted;
  logic        take;

  assign shifted = {rem, 1'b0};
  assign take    = (shifted >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'(rcpd_pkg::QUO_BITS);
      end else if (busy) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsr <= den;
      quo <= '0;
    end else if (busy) begin
      if (take) begin
        rem <= 16'(shifted - {1'b0, dsr});
      end else begin
        rem <= shifted[15:0];
      end
      quo <= {quo[rcpd_pkg::QUO_BITS-2:0], take};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rcpd_datapath.sv =====
// Datapath: pulse measurement state, normalization, mixing and output register.
`timescale 1ns / 1ps
`default_nettype none
module rcpd_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire rcpd_pkg::cfg_t cfg,
  input  wire rcpd_pkg::cmd_t cmd,
  output rcpd_pkg::stat_t     stat,
  input  wire rcpd_pkg::in_t  in_data,
  input  wire logic           out_ready,
  output logic                out_valid,
  output rcpd_pkg::out_t      out_data
);

  localparam int CW = rcpd_pkg::COUNT_BITS;
  localparam int MW = rcpd_pkg::MAG_BITS;

  // measurement state
  logic [2:0]    expect_falling;
  logic [CW-1:0] rising_count [3];
  logic [CW-1:0] steering_width;
  logic [CW-1:0] throttle_width;
  logic          steering_valid;
  logic          throttle_valid;
  logic          too_close;

  // normalized values as sign and magnitude
  logic          steer_neg;
  logic [MW-1:0] steer_mag;
  logic          thr_neg;
  logic [MW-1:0] thr_mag;

  logic [CW-1:0] cap_width;
  logic          cap_chan_ok;
  logic [1:0]    cap_ch;

  assign cap_chan_ok = (in_data.op == rcpd_pkg::OP_STEER) ||
                       (in_data.op == rcpd_pkg::OP_THROTTLE) ||
                       (in_data.op == rcpd_pkg::OP_RANGE);
  assign cap_ch      = in_data.op;
  assign cap_width   = CW'(rising_count[cap_ch] - in_data.captured_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_falling  <= '0;
      rising_count[0] <= '0;
      rising_count[1] <= '0;
      rising_count[2] <= '0;
      steering_width  <= '0;
      throttle_width  <= '0;
      steering_valid  <= 1'b0;
      throttle_valid  <= 1'b0;
      too_close       <= 1'b0;
    end else if (cmd.capture) begin
      too_close <= 1'b0;
      if (cap_chan_ok) begin
        if (!expect_falling[cap_ch]) begin
          rising_count[cap_ch]   <= in_data.captured_count;
          expect_falling[cap_ch] <= 1'b1;
        end else begin
          expect_falling[cap_ch] <= 1'b0;
          case (cap_ch)
            rcpd_pkg::OP_STEER: begin
              steering_width <= cap_width;
              steering_valid <= 1'b1;
            end
            rcpd_pkg::OP_THROTTLE: begin
              throttle_width <= cap_width;
              throttle_valid <= 1'b1;
            end
            default: begin
              too_close <= (cap_width < cfg.safe_distance);
            end
          endcase
        end
      end
    end
  end

  // normalization setup
  logic [CW-1:0] n_width;
  logic          n_valid;
  logic [16:0]   n_d;
  logic          n_neg;
  logic [15:0]   n_abs;
  logic [16:0]   n_den;
  logic          n_den_bad;
  logic          n_zero;
  logic          n_full;

  assign n_width   = cmd.norm_sel ? throttle_width : steering_width;
  assign n_valid   = cmd.norm_sel ? throttle_valid : steering_valid;
  assign n_d       = {1'b0, n_width} - {1'b0, cfg.stick_center};
  assign n_neg     = n_d[16];
  assign n_abs     = n_neg ? 16'(-n_d) : n_d[15:0];
  assign n_den     = n_neg ? ({1'b0, cfg.stick_center} - {1'b0, cfg.stick_min})
                           : ({1'b0, cfg.stick_max} - {1'b0, cfg.stick_center});
  assign n_den_bad = n_den[16] || (n_den == 17'd0);
  assign n_zero    = !n_valid || (n_abs <= {8'd0, cfg.dead_margin});
  assign n_full    = n_den_bad || (n_abs >= n_den[15:0]);

  logic                          div_done;
  logic [rcpd_pkg::QUO_BITS-1:0] div_quo;

  rcpd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.norm_start),
    .num   (n_abs),
    .den   (n_den[15:0]),
    .quo   (div_quo),
    .done  (div_done)
  );

  logic          k_zero;
  logic          k_full;
  logic          k_neg;
  logic          k_sel;
  logic [MW-1:0] k_mag;

  always_ff @(posedge clk) begin
    if (cmd.norm_start) begin
      k_zero <= n_zero;
      k_full <= n_full;
      k_neg  <= n_neg;
      k_sel  <= cmd.norm_sel;
    end
  end

  always_comb begin
    if (k_zero) begin
      k_mag = '0;
    end else if (k_full) begin
      k_mag = rcpd_pkg::ONE_Q15;
    end else begin
      k_mag = {1'b0, div_quo};
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      if (k_sel) begin
        thr_mag <= k_mag;
        thr_neg <= k_neg && (k_mag != '0);
      end else begin
        steer_mag <= k_mag;
        steer_neg <= k_neg && (k_mag != '0);
      end
    end
  end

  assign stat.norm_done = div_done;

  // mixing
  logic          fwd;
  logic [MW-1:0] speed;
  logic [MW-1:0] inner;
  logic [MW-1:0] left_val;
  logic [MW-1:0] right_val;
  logic [MW-1:0] mul_a;
  logic [MW-1:0] mul_b;
  logic [31:0]   prod;
  logic [rcpd_pkg::DRIVE_BITS-1:0] left_drive;

  assign fwd       = !thr_neg;
  assign speed     = (too_close && fwd) ? '0 : thr_mag;
  assign left_val  = steer_neg ? inner : speed;
  assign right_val = (!steer_neg && (steer_mag != '0)) ? inner : speed;

  always_comb begin
    case (cmd.mul_sel)
      rcpd_pkg::MUL_INNER: begin
        mul_a = speed;
        mul_b = MW'(rcpd_pkg::ONE_Q15 - steer_mag);
      end
      rcpd_pkg::MUL_LEFT: begin
        mul_a = left_val;
        mul_b = {4'd0, cfg.full_drive};
      end
      rcpd_pkg::MUL_RIGHT: begin
        mul_a = right_val;
        mul_b = {4'd0, cfg.full_drive};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.inner_load) begin
      inner <= prod[30:15];
    end
    if (cmd.left_load) begin
      left_drive <= prod[26:15];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_data.left_drive  <= left_drive;
      out_data.right_drive <= prod[26:15];
      out_data.forward     <= fwd;
    end
  end

  assign stat.out_full = out_valid && !out_ready;

endmodule
`default_nettype wire

// ===== rtl/rcpd_ctrl.sv =====
// Controller: sequences capture, two normalizations, three multiplies, output.
`timescale 1ns / 1ps
`default_nettype none
module rcpd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output rcpd_pkg::cmd_t       cmd,
  input  wire rcpd_pkg::stat_t stat
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_NORM_S  = 4'd1;
  localparam logic [3:0] S_WAIT_S  = 4'd2;
  localparam logic [3:0] S_NORM_T  = 4'd3;
  localparam logic [3:0] S_WAIT_T  = 4'd4;
  localparam logic [3:0] S_MUL_I   = 4'd5;
  localparam logic [3:0] S_LOAD_I  = 4'd6;
  localparam logic [3:0] S_MUL_L   = 4'd7;
  localparam logic [3:0] S_MUL_R   = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_NORM_S;
        end
      end
      S_NORM_S: begin
        cmd.norm_start = 1'b1;
        state_next     = S_WAIT_S;
      end
      S_WAIT_S: begin
        if (stat.norm_done) begin
          state_next = S_NORM_T;
        end
      end
      S_NORM_T: begin
        cmd.norm_start = 1'b1;
        cmd.norm_sel   = 1'b1;
        state_next     = S_WAIT_T;
      end
      S_WAIT_T: begin
        cmd.norm_sel = 1'b1;
        if (stat.norm_done) begin
          state_next = S_MUL_I;
        end
      end
      S_MUL_I: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = rcpd_pkg::MUL_INNER;
        state_next  = S_LOAD_I;
      end
      S_LOAD_I: begin
        cmd.inner_load = 1'b1;
        state_next     = S_MUL_L;
      end
      S_MUL_L: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = rcpd_pkg::MUL_LEFT;
        state_next  = S_MUL_R;
      end
      S_MUL_R: begin
        cmd.left_load = 1'b1;
        cmd.mul_go    = 1'b1;
        cmd.mul_sel   = rcpd_pkg::MUL_RIGHT;
        state_next    = S_FIN;
      end
      S_FIN: begin
        // hold until the output register frees up
        if (!stat.out_full) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire
